// File: src/tqegh_pkg.sv
// package for the trivariate quartic evaluator: sizes, monomial tables, command types
// used by tqegh_ctrl, tqegh_dp and trivariate_quartic_eval_grad_hess_core
// no dependencies
package tqegh_pkg;

   localparam int NUM_TERMS  = 35;
   localparam int COEF_WIDTH = 48;
   localparam int NUM_OUT    = 10;
   localparam int LIMBS      = 6;
   localparam int TERM_WIDTH = LIMBS * 32;
   localparam int ACC_WIDTH  = 192;
   localparam int RES_LSB    = 56;
   localparam int RES_WIDTH  = 64;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   typedef enum logic [1:0] {
      SEL_MULT = 2'd0,
      SEL_X1   = 2'd1,
      SEL_X2   = 2'd2,
      SEL_X3   = 2'd3
   } sel_type;

   // exponents of x1, x2, x3 per table slot
   localparam logic [2:0] MONO_EXP [NUM_TERMS][3] = '{
      '{3'd0,3'd0,3'd0},
      '{3'd1,3'd0,3'd0}, '{3'd0,3'd1,3'd0}, '{3'd0,3'd0,3'd1},
      '{3'd2,3'd0,3'd0}, '{3'd1,3'd1,3'd0}, '{3'd1,3'd0,3'd1},
      '{3'd0,3'd2,3'd0}, '{3'd0,3'd1,3'd1}, '{3'd0,3'd0,3'd2},
      '{3'd3,3'd0,3'd0}, '{3'd2,3'd1,3'd0}, '{3'd2,3'd0,3'd1},
      '{3'd1,3'd2,3'd0}, '{3'd1,3'd1,3'd1}, '{3'd1,3'd0,3'd2},
      '{3'd0,3'd3,3'd0}, '{3'd0,3'd2,3'd1}, '{3'd0,3'd1,3'd2},
      '{3'd0,3'd0,3'd3},
      '{3'd4,3'd0,3'd0}, '{3'd3,3'd1,3'd0}, '{3'd3,3'd0,3'd1},
      '{3'd2,3'd2,3'd0}, '{3'd2,3'd1,3'd1}, '{3'd2,3'd0,3'd2},
      '{3'd1,3'd3,3'd0}, '{3'd1,3'd2,3'd1}, '{3'd1,3'd1,3'd2},
      '{3'd1,3'd0,3'd3}, '{3'd0,3'd4,3'd0}, '{3'd0,3'd3,3'd1},
      '{3'd0,3'd2,3'd2}, '{3'd0,3'd1,3'd3}, '{3'd0,3'd0,3'd4}
   };

   // derivative orders per output: value, gradient, hessian
   localparam logic [2:0] DERIV_ORD [NUM_OUT][3] = '{
      '{3'd0,3'd0,3'd0},
      '{3'd1,3'd0,3'd0}, '{3'd0,3'd1,3'd0}, '{3'd0,3'd0,3'd1},
      '{3'd2,3'd0,3'd0}, '{3'd1,3'd1,3'd0}, '{3'd1,3'd0,3'd1},
      '{3'd0,3'd2,3'd0}, '{3'd0,3'd1,3'd1}, '{3'd0,3'd0,3'd2}
   };

   typedef struct packed {
      logic       ok;
      logic [3:0] mult;
      logic [2:0] pw1;
      logic [2:0] pw2;
      logic [2:0] pw3;
      logic [2:0] deg;
   } term_info_type;

   typedef struct packed {
      logic       capture;
      logic       wr_en;
      logic       rd_en;
      logic [5:0] addr;
      logic       load_term;
      logic       mul_en;
      logic [2:0] limb;
      sel_type    sel;
      logic [3:0] mult;
      logic       acc_en;
      logic [2:0] deg;
      logic       save;
      logic [3:0] slot;
      logic       publish;
   } dp_cmd_type;

   typedef struct packed {
      logic slot_free;
      logic rsp_busy;
   } dp_status_type;

   // what output k needs from term t: surviving powers, multiplier, degree
   function automatic term_info_type term_info(input logic [3:0] k, input logic [5:0] t);
      term_info_type r;
      int            e;
      int            d;
      int            m;
      int            dg;
      int            pw [3];
      r  = '0;
      r.ok = 1'b1;
      m  = 1;
      dg = 0;
      for (int v = 0; v < 3; v++) begin
         e = int'(MONO_EXP[t][v]);
         d = int'(DERIV_ORD[k][v]);
         if (e < d) r.ok = 1'b0;
         pw[v] = (e >= d) ? e - d : 0;
         if (d >= 1) m = m * e;
         if (d >= 2) m = m * (e - 1);
         dg = dg + pw[v];
      end
      r.mult = 4'(m);
      r.pw1  = 3'(pw[0]);
      r.pw2  = 3'(pw[1]);
      r.pw3  = 3'(pw[2]);
      r.deg  = 3'(dg);
      return r;
   endfunction

endpackage

// File: src/tqegh_ctrl.sv
// sequencer for the trivariate quartic evaluator
// walks outputs, table slots, factors and limbs; drives tqegh_dp; uses tqegh_pkg
module tqegh_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_command,
   output logic                    req_ready,
   input  tqegh_pkg::dp_status_type status,
   output tqegh_pkg::dp_cmd_type   cmd
);

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_READ = 8'b0000_0010,
      ST_LOAD = 8'b0000_0100,
      ST_MUL  = 8'b0000_1000,
      ST_ACC  = 8'b0001_0000,
      ST_NEXT = 8'b0010_0000,
      ST_SAVE = 8'b0100_0000,
      ST_DONE = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [3:0] k_ff, k_in;
   logic [5:0] t_ff, t_in;
   logic [2:0] fidx_ff, fidx_in;
   logic [2:0] limb_ff, limb_in;

   tqegh_pkg::term_info_type info;
   logic [3:0]               nf;
   logic [3:0]               b1;
   logic [3:0]               b2;
   tqegh_pkg::sel_type       sel;

   assign info = tqegh_pkg::term_info(k_ff, t_ff);
   assign nf   = 4'd1 + 4'(info.pw1) + 4'(info.pw2) + 4'(info.pw3);
   assign b1   = 4'(info.pw1);
   assign b2   = 4'(info.pw1) + 4'(info.pw2);

   // factor 0 is the derivative multiplier, then x1, x2, x3 powers in turn
   always_comb begin
      if (fidx_ff == 3'd0) sel = tqegh_pkg::SEL_MULT;
      else if (4'(fidx_ff) <= b1) sel = tqegh_pkg::SEL_X1;
      else if (4'(fidx_ff) <= b2) sel = tqegh_pkg::SEL_X2;
      else sel = tqegh_pkg::SEL_X3;
   end

   always_comb begin
      state_in  = state_ff;
      k_in      = k_ff;
      t_in      = t_ff;
      fidx_in   = fidx_ff;
      limb_in   = limb_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.addr  = t_ff;
      cmd.limb  = limb_ff;
      cmd.sel   = sel;
      cmd.mult  = info.mult;
      cmd.deg   = info.deg;
      cmd.slot  = k_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_command == tqegh_pkg::CMD_EVAL) begin
                  cmd.capture = 1'b1;
                  k_in        = '0;
                  t_in        = '0;
                  state_in    = ST_READ;
               end else begin
                  cmd.wr_en = 1'b1;
               end
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load_term = 1'b1;
            fidx_in       = '0;
            limb_in       = '0;
            state_in      = info.ok ? ST_MUL : ST_NEXT;
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            if (limb_ff == 3'(tqegh_pkg::LIMBS - 1)) begin
               limb_in = '0;
               if (4'(fidx_ff) == nf - 4'd1) state_in = ST_ACC;
               else fidx_in = fidx_ff + 3'd1;
            end else begin
               limb_in = limb_ff + 3'd1;
            end
         end
         ST_ACC: begin
            cmd.acc_en = 1'b1;
            state_in   = ST_NEXT;
         end
         ST_NEXT: begin
            if (t_ff == 6'(tqegh_pkg::NUM_TERMS - 1)) begin
               state_in = ST_SAVE;
            end else begin
               t_in     = t_ff + 6'd1;
               state_in = ST_READ;
            end
         end
         ST_SAVE: begin
            cmd.save = 1'b1;
            if (k_ff == 4'(tqegh_pkg::NUM_OUT - 1)) begin
               state_in = ST_DONE;
            end else begin
               k_in     = k_ff + 4'd1;
               t_in     = '0;
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            if (status.slot_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
         t_ff     <= '0;
         fidx_ff  <= '0;
         limb_ff  <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         t_ff     <= t_in;
         fidx_ff  <= fidx_in;
         limb_ff  <= limb_in;
      end
   end

endmodule

// File: src/tqegh_dp.sv
// datapath for the trivariate quartic evaluator: coefficient memory, limb multiplier,
// wide accumulator, saturation and result registers; uses tqegh_pkg
module tqegh_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  tqegh_pkg::dp_cmd_type       cmd,
   output tqegh_pkg::dp_status_type    status,
   input  logic [5:0]                  req_coef_index,
   input  logic signed [47:0]          req_coef_value,
   input  logic signed [31:0]          req_coord_1,
   input  logic signed [31:0]          req_coord_2,
   input  logic signed [31:0]          req_coord_3,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic [tqegh_pkg::NUM_OUT-1:0][63:0] rsp_data,
   output logic                        rsp_overflow
);

   localparam int CW = tqegh_pkg::COEF_WIDTH;
   localparam int TW = tqegh_pkg::TERM_WIDTH;
   localparam int AW = tqegh_pkg::ACC_WIDTH;
   localparam int LO = tqegh_pkg::RES_LSB;
   localparam int RW = tqegh_pkg::RES_WIDTH;

   logic [CW-1:0] mem [tqegh_pkg::NUM_TERMS];
   logic [tqegh_pkg::NUM_TERMS-1:0] valid_ff;
   logic [CW-1:0] rdata_ff;
   logic          rvalid_ff;

   logic [2:0][31:0] cmag_ff;
   logic [2:0]       cneg_ff;
   logic [tqegh_pkg::LIMBS-1:0][31:0] term_ff, term_in;
   logic             neg_ff, neg_in;
   logic [31:0]      carry_ff, carry_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic             sat_ff, sat_in;
   logic [tqegh_pkg::NUM_OUT-1:0][RW-1:0] res_ff;
   logic [tqegh_pkg::NUM_OUT-1:0][RW-1:0] out_ff;
   logic             ovf_ff;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [CW-1:0]    coef;
   logic [CW-1:0]    coef_mag;
   logic [31:0]      mfac;
   logic             mfac_neg;
   logic [63:0]      prod;
   logic [63:0]      psum;
   logic [TW-1:0]    shifted;
   logic [AW-RW-LO:0] upper;
   logic             fits;
   logic [RW-1:0]    sat_val;

   // coefficient memory, valid bits make unwritten slots read as zero
   always_ff @(posedge clock) begin
      if (cmd.wr_en && req_coef_index < 6'(tqegh_pkg::NUM_TERMS))
         mem[req_coef_index] <= req_coef_value;
      if (cmd.rd_en) rdata_ff <= mem[cmd.addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (cmd.wr_en && req_coef_index < 6'(tqegh_pkg::NUM_TERMS))
            valid_ff[req_coef_index] <= 1'b1;
         if (cmd.rd_en) rvalid_ff <= valid_ff[cmd.addr];
      end
   end

   assign coef     = rvalid_ff ? rdata_ff : '0;
   assign coef_mag = coef[CW-1] ? CW'(0) - coef : coef;

   always_comb begin
      case (cmd.sel)
         tqegh_pkg::SEL_MULT: begin mfac = 32'(cmd.mult); mfac_neg = 1'b0;       end
         tqegh_pkg::SEL_X1:   begin mfac = cmag_ff[0];    mfac_neg = cneg_ff[0]; end
         tqegh_pkg::SEL_X2:   begin mfac = cmag_ff[1];    mfac_neg = cneg_ff[1]; end
         tqegh_pkg::SEL_X3:   begin mfac = cmag_ff[2];    mfac_neg = cneg_ff[2]; end
         default:             begin mfac = 32'd0;         mfac_neg = 1'b0;       end
      endcase
   end

   assign prod = 64'(term_ff[cmd.limb]) * 64'(mfac);
   assign psum = prod + 64'((cmd.limb == 3'd0) ? 32'd0 : carry_ff);

   // term lands at scale 2^-88: shift by 16 per missing degree
   always_comb begin
      case (cmd.deg)
         3'd0:    shifted = term_ff << 64;
         3'd1:    shifted = term_ff << 48;
         3'd2:    shifted = term_ff << 32;
         3'd3:    shifted = term_ff << 16;
         default: shifted = term_ff;
      endcase
   end

   assign upper   = acc_ff[AW-1:LO+RW-1];
   assign fits    = (&upper) || !(|upper);
   assign sat_val = acc_ff[AW-1] ? {1'b1, {(RW-1){1'b0}}} : {1'b0, {(RW-1){1'b1}}};

   always_comb begin
      term_in  = term_ff;
      neg_in   = neg_ff;
      carry_in = carry_ff;
      acc_in   = acc_ff;
      sat_in   = sat_ff;
      if (cmd.load_term) begin
         term_in = TW'(coef_mag);
         neg_in  = coef[CW-1];
      end
      if (cmd.mul_en) begin
         term_in[cmd.limb] = psum[31:0];
         carry_in          = psum[63:32];
         if (cmd.limb == 3'd0 && mfac_neg) neg_in = !neg_ff;
      end
      if (cmd.acc_en) acc_in = neg_ff ? acc_ff - AW'(shifted) : acc_ff + AW'(shifted);
      if (cmd.save) begin
         acc_in = '0;
         if (!fits) sat_in = 1'b1;
      end
      if (cmd.capture) begin
         acc_in = '0;
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      term_ff  <= term_in;
      neg_ff   <= neg_in;
      carry_ff <= carry_in;
      acc_ff   <= acc_in;
      sat_ff   <= sat_in;
      if (cmd.capture) begin
         cmag_ff[0] <= req_coord_1[31] ? 32'd0 - req_coord_1 : req_coord_1;
         cmag_ff[1] <= req_coord_2[31] ? 32'd0 - req_coord_2 : req_coord_2;
         cmag_ff[2] <= req_coord_3[31] ? 32'd0 - req_coord_3 : req_coord_3;
         cneg_ff    <= {req_coord_3[31], req_coord_2[31], req_coord_1[31]};
      end
      if (cmd.save) res_ff[cmd.slot] <= fits ? acc_ff[LO+RW-1:LO] : sat_val;
      if (cmd.publish) begin
         out_ff <= res_ff;
         ovf_ff <= sat_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.publish) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   assign status.slot_free = !rsp_valid_ff || rsp_ready;
   assign status.rsp_busy  = rsp_valid_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = out_ff;
   assign rsp_overflow     = ovf_ff;

endmodule

// File: src/trivariate_quartic_eval_grad_hess_core.sv
// top level of the trivariate quartic evaluator: value, gradient and hessian
// instantiates tqegh_ctrl and tqegh_dp; uses tqegh_pkg

// A load beat (command 0) writes one Q24.24 coefficient into the 35-slot table; slots
// at index 35 and above are ignored, and all slots read as zero after reset.
// An evaluate beat (command 1) takes a Q16.16 point and returns one beat with the value,
// three gradient and six hessian entries, each floored to Q32.32 and saturated, plus an
// overflow flag. In an evaluate, every one of the ten outputs walks all 35 slots (read,
// load, next), and each contributing term is multiplied limb by limb by every factor
// (derivative multiplier, then one factor per coordinate power) on the single 32x32 limb
// multiplier, then added into the 192-bit accumulator. A new beat is taken only when the
// sequencer is idle; a finished result sits in its own output register, so loads and the
// next evaluate can start while it waits for the consumer.
module trivariate_quartic_eval_grad_hess_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_command,
   input  logic [5:0]         req_coef_index,
   input  logic signed [47:0] req_coef_value,
   input  logic signed [31:0] req_coord_1,
   input  logic signed [31:0] req_coord_2,
   input  logic signed [31:0] req_coord_3,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [63:0] rsp_energy,
   output logic signed [63:0] rsp_grad_1,
   output logic signed [63:0] rsp_grad_2,
   output logic signed [63:0] rsp_grad_3,
   output logic signed [63:0] rsp_hess_11,
   output logic signed [63:0] rsp_hess_12,
   output logic signed [63:0] rsp_hess_13,
   output logic signed [63:0] rsp_hess_22,
   output logic signed [63:0] rsp_hess_23,
   output logic signed [63:0] rsp_hess_33,
   output logic               rsp_overflow
);

   tqegh_pkg::dp_cmd_type    cmd;
   tqegh_pkg::dp_status_type status;
   logic [tqegh_pkg::NUM_OUT-1:0][63:0] rsp_data;

   // sequencer: one evaluate at a time
   tqegh_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .status      (status),
      .cmd         (cmd)
   );

   // table, multiplier, accumulator and output register
   tqegh_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .req_coord_1    (req_coord_1),
      .req_coord_2    (req_coord_2),
      .req_coord_3    (req_coord_3),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .rsp_overflow   (rsp_overflow)
   );

   // output order follows the derivative list: value, gradient, hessian
   assign rsp_energy  = rsp_data[0];
   assign rsp_grad_1  = rsp_data[1];
   assign rsp_grad_2  = rsp_data[2];
   assign rsp_grad_3  = rsp_data[3];
   assign rsp_hess_11 = rsp_data[4];
   assign rsp_hess_12 = rsp_data[5];
   assign rsp_hess_13 = rsp_data[6];
   assign rsp_hess_22 = rsp_data[7];
   assign rsp_hess_23 = rsp_data[8];
   assign rsp_hess_33 = rsp_data[9];

`ifndef SYNTH
   // a result is only published into a free output slot
   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!status.rsp_busy || rsp_ready))
      else $error("result published over a pending beat");

   // an accepted evaluate leaves the sequencer busy
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_command == tqegh_pkg::CMD_EVAL) |=> !req_ready)
      else $error("sequencer idle right after evaluate");

   // datapath work never overlaps intake
   a_work_not_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.mul_en || cmd.acc_en || cmd.save) |-> !req_ready)
      else $error("datapath busy while taking beats");
`endif

endmodule

// File: verif/trivariate_quartic_eval_grad_hess_core_test.sv
// testbench for trivariate_quartic_eval_grad_hess_core: directed and random load/evaluate beats
// checked against an exact wide-integer model of value, gradient and hessian
// depends on tqegh_pkg and the core rtl
`timescale 1ns / 1ps

module trivariate_quartic_eval_grad_hess_core_test;

   localparam int CYCLE_LIMIT = 30000000;
   localparam int DRAIN_CYCLES = 400;

   typedef struct packed {
      logic [9:0][63:0] val;
      logic             ovf;
   } eval_result_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_command;
   logic [5:0]         req_coef_index;
   logic signed [47:0] req_coef_value;
   logic signed [31:0] req_coord_1;
   logic signed [31:0] req_coord_2;
   logic signed [31:0] req_coord_3;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [63:0] rsp_energy;
   logic signed [63:0] rsp_grad_1;
   logic signed [63:0] rsp_grad_2;
   logic signed [63:0] rsp_grad_3;
   logic signed [63:0] rsp_hess_11;
   logic signed [63:0] rsp_hess_12;
   logic signed [63:0] rsp_hess_13;
   logic signed [63:0] rsp_hess_22;
   logic signed [63:0] rsp_hess_23;
   logic signed [63:0] rsp_hess_33;
   logic               rsp_overflow;

   // shadow of the coefficient table and the monomial exponents in graded lex order
   logic signed [47:0] coef_shadow [tqegh_pkg::NUM_TERMS];
   int                 expo [tqegh_pkg::NUM_TERMS][3];
   eval_result_type    pending_evals [$];
   int                 mismatches = 0;
   int                 cycles = 0;
   int                 beats_sent = 0;
   bit                 quiet = 1'b0;      // no idling on either side
   bit                 hold_done = 1'b0;

   trivariate_quartic_eval_grad_hess_core i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // runaway guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // build the exponent table: degree by degree, lexicographic inside a degree
   task automatic build_exponents();
      int n;
      n = 0;
      for (int dg = 0; dg <= 4; dg++)
         for (int a = dg; a >= 0; a--)
            for (int b = dg - a; b >= 0; b--) begin
               expo[n][0] = a;
               expo[n][1] = b;
               expo[n][2] = dg - a - b;
               n++;
            end
   endtask

   // exact value, gradient and hessian; outputs use the first ten exponent rows as orders
   function automatic eval_result_type quartic_derivs(logic signed [31:0] c1,
                                                      logic signed [31:0] c2,
                                                      logic signed [31:0] c3);
      eval_result_type    r;
      logic signed [255:0] acc;
      logic signed [255:0] term;
      logic signed [255:0] hi;
      logic signed [255:0] cw [3];
      logic signed [255:0] top;
      logic signed [255:0] bot;
      int                  e;
      int                  d;
      int                  mult;
      int                  dg;
      bit                  skip;
      cw[0] = c1;
      cw[1] = c2;
      cw[2] = c3;
      top = 256'sh7FFF_FFFF_FFFF_FFFF;
      bot = -top - 1;
      r.ovf = 1'b0;
      for (int k = 0; k < 10; k++) begin
         acc = '0;
         for (int t = 0; t < tqegh_pkg::NUM_TERMS; t++) begin
            skip = 1'b0;
            mult = 1;
            dg = 0;
            for (int v = 0; v < 3; v++) begin
               e = expo[t][v];
               d = expo[k][v];
               if (e < d) skip = 1'b1;
               if (d >= 1) mult = mult * e;
               if (d >= 2) mult = mult * (e - 1);
               dg = dg + e - d;
            end
            if (!skip) begin
               term = coef_shadow[t];
               term = term * mult;
               for (int v = 0; v < 3; v++)
                  for (int p = 0; p < expo[t][v] - expo[k][v]; p++)
                     term = term * cw[v];
               // bring every term to a 2^-88 scale
               term = term <<< (16 * (4 - dg));
               acc = acc + term;
            end
         end
         hi = acc >>> 56;   // floor to q32.32
         if (hi > top) begin
            r.val[k] = 64'h7FFF_FFFF_FFFF_FFFF;
            r.ovf = 1'b1;
         end else if (hi < bot) begin
            r.val[k] = 64'h8000_0000_0000_0000;
            r.ovf = 1'b1;
         end else
            r.val[k] = hi[63:0];
      end
      return r;
   endfunction

   // one request beat; entered and left at a falling edge
   task automatic send_beat(logic cmd, logic [5:0] idx, logic [47:0] cv,
                            logic [31:0] c1, logic [31:0] c2, logic [31:0] c3);
      if (!quiet && $urandom_range(99) < 14) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_command    = cmd;
      req_coef_index = idx;
      req_coef_value = cv;
      req_coord_1    = c1;
      req_coord_2    = c2;
      req_coord_3    = c3;
      req_valid      = 1'b1;
      do @(posedge clock); while (!req_ready);
      if (cmd == tqegh_pkg::CMD_EVAL)
         pending_evals.push_back(quartic_derivs(c1, c2, c3));
      else if (idx < tqegh_pkg::NUM_TERMS)
         coef_shadow[idx] = cv;
      beats_sent++;
      @(negedge clock);
   endtask

   // result checker: compare every accepted beat with the oldest expectation
   always @(posedge clock) begin
      eval_result_type got;
      eval_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.val = {rsp_hess_33, rsp_hess_23, rsp_hess_22, rsp_hess_13, rsp_hess_12,
                    rsp_hess_11, rsp_grad_3, rsp_grad_2, rsp_grad_1, rsp_energy};
         got.ovf = rsp_overflow;
         if (pending_evals.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat");
         end else begin
            want = pending_evals.pop_front();
            for (int k = 0; k < 10; k++)
               if (got.val[k] !== want.val[k]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("output %0d: expected %h, got %h", k, want.val[k], got.val[k]);
               end
            if (got.ovf !== want.ovf) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("overflow: expected %b, got %b", want.ovf, got.ovf);
            end
         end
      end
   end

   // consumer: random stalls, plus one long hold-off so the core backs up
   initial begin
      int held;
      held = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && beats_sent >= 700 && held < 12000) begin
            held++;
            rsp_ready <= 1'b0;
            if (held == 12000) hold_done = 1'b1;
         end else
            rsp_ready <= quiet || ($urandom_range(99) >= 14);
      end
   end

   function automatic logic [47:0] rand_coef();
      if ($urandom_range(3) == 0) return 48'({$urandom, $urandom});
      return 48'($signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000);
   endfunction

   function automatic logic [31:0] rand_coord();
      if ($urandom_range(4) == 0) return $urandom;
      return 32'($signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000);
   endfunction

   task automatic test_cleared_table();
      send_beat(tqegh_pkg::CMD_EVAL, 6'd0, '0, 32'h0, 32'h0, 32'h0);
      send_beat(tqegh_pkg::CMD_EVAL, 6'd63, 48'hFFFF_FFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'hFFFF_FFFF);
   endtask

   task automatic test_single_terms();
      send_beat(tqegh_pkg::CMD_LOAD, 6'd0, 48'h7FFF_FFFF_FFFF, '0, '0, '0);
      send_beat(tqegh_pkg::CMD_EVAL, '0, '0, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000);
      send_beat(tqegh_pkg::CMD_LOAD, 6'd0, 48'h0, '0, '0, '0);
      send_beat(tqegh_pkg::CMD_LOAD, 6'd14, 48'h0000_0100_0000, '0, '0, '0);   // x1 x2 x3
      send_beat(tqegh_pkg::CMD_LOAD, 6'd20, 48'hFFFF_FF00_0000, '0, '0, '0);   // x1^4
      send_beat(tqegh_pkg::CMD_LOAD, 6'd34, 48'h0000_0080_0000, '0, '0, '0);   // x3^4
      send_beat(tqegh_pkg::CMD_EVAL, '0, '0, 32'h0003_8000, 32'hFFFE_0000, 32'h0000_4000);
   endtask

   task automatic test_ignored_slots();
      send_beat(tqegh_pkg::CMD_LOAD, 6'd35, 48'h1234_5678_9ABC, '0, '0, '0);
      send_beat(tqegh_pkg::CMD_LOAD, 6'd63, 48'h8000_0000_0000, '0, '0, '0);
      send_beat(tqegh_pkg::CMD_EVAL, 6'd34, 48'h7FFF_FFFF_FFFF, 32'h0001_0000, 32'h0001_0000,
                32'h0001_0000);
   endtask

   task automatic test_saturation();
      send_beat(tqegh_pkg::CMD_LOAD, 6'd20, 48'h7FFF_FFFF_FFFF, '0, '0, '0);
      send_beat(tqegh_pkg::CMD_LOAD, 6'd30, 48'h8000_0000_0000, '0, '0, '0);
      send_beat(tqegh_pkg::CMD_EVAL, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_beat(tqegh_pkg::CMD_EVAL, '0, '0, 32'h8000_0000, 32'h0000_0001, 32'h8000_0000);
      send_beat(tqegh_pkg::CMD_EVAL, '0, '0, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
   endtask

   task automatic test_random_traffic();
      logic cmd;
      logic [5:0] idx;
      for (int n = 0; n < 1230; n++) begin
         quiet = (n >= 300 && n < 500);
         cmd = ($urandom_range(99) < 15) ? tqegh_pkg::CMD_EVAL : tqegh_pkg::CMD_LOAD;
         idx = ($urandom_range(9) == 0) ? 6'($urandom_range(35, 63))
                                        : 6'($urandom_range(0, tqegh_pkg::NUM_TERMS - 1));
         send_beat(cmd, idx, rand_coef(), rand_coord(), rand_coord(), rand_coord());
      end
      quiet = 1'b0;
   endtask

   initial begin
      for (int t = 0; t < tqegh_pkg::NUM_TERMS; t++) coef_shadow[t] = '0;
      build_exponents();
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_command    = tqegh_pkg::CMD_LOAD;
      req_coef_index = '0;
      req_coef_value = '0;
      req_coord_1    = '0;
      req_coord_2    = '0;
      req_coord_3    = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_cleared_table();
      test_single_terms();
      test_ignored_slots();
      test_saturation();
      test_random_traffic();
      req_valid = 1'b0;

      wait (pending_evals.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_evals.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// File: sim.f
src/tqegh_pkg.sv
src/tqegh_ctrl.sv
src/tqegh_dp.sv
src/trivariate_quartic_eval_grad_hess_core.sv
verif/trivariate_quartic_eval_grad_hess_core_test.sv
